// ----- rtl/s2a_pkg.sv -----
// Shared types, constants and scancode translation ROMs for the keyboard ring buffer.
package s2a_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int FILL_W       = 7;
    localparam int ROM_LEN      = 83;
    localparam int ROM_IDX_W    = $clog2(ROM_LEN);

    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] CHAR_NONE     = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_SCAN = 2'd0,
        FUNC_PUSH = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } s2a_in_t;

    typedef struct packed {
        logic [7:0]        read_char;
        logic              read_valid;
        logic              stored;
        logic [FILL_W-1:0] fill_level;
    } s2a_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } ring_stat_t;

    localparam logic [7:0] ROM_PLAIN [ROM_LEN] = '{
        8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
        8'h30,8'h2D,8'h3D,8'h08,8'h00,8'h71,8'h77,8'h65,8'h72,
        8'h74,8'h79,8'h75,8'h69,8'h6F,8'h70,8'h5B,8'h5D,8'h0A,
        8'h00,8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,8'h6A,
        8'h6B,8'h6C,8'h3B,8'h27,8'h60,8'h00,8'h5C,
        8'h7A,8'h78,8'h63,8'h76,8'h62,8'h6E,8'h6D,8'h2C,8'h2E,
        8'h2F,8'h00,8'h2A,8'h00,8'h20,
        8'h00,8'hF1,8'hF2,8'hF3,8'hF4,
        8'hF5,8'hF6,8'hF7,8'hF8,8'h03,8'h02,
        8'h00,8'h00,8'h00,8'h01,8'h00,
        8'h2D,8'h04,8'h00,8'h02,8'h2B,8'h00,8'h03,
        8'h00,8'h00,8'h00
    };

    localparam logic [7:0] ROM_SHIFT [ROM_LEN] = '{
        8'h00,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,
        8'h29,8'h5F,8'h2B,8'h08,8'h00,8'h51,8'h57,8'h45,8'h52,
        8'h54,8'h59,8'h55,8'h49,8'h4F,8'h50,8'h7B,8'h7D,8'h0D,
        8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,8'h4A,
        8'h4B,8'h4C,8'h3A,8'h22,8'h7E,8'h00,8'h7C,
        8'h5A,8'h58,8'h43,8'h56,8'h42,8'h4E,8'h4D,8'h3C,8'h3E,
        8'h3F,8'h00,8'h00,8'h00,8'h20,
        8'h00,8'h00,8'h00,8'h50,8'h00,
        8'h00,8'h00,8'h01,8'h04,8'h03,8'h02,
        8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00
    };

    // Make codes 1..83 map through the ROMs; everything else gives no character.
    function automatic logic [7:0] s2a_lookup(input logic shift, input logic [7:0] code);
        logic [ROM_IDX_W-1:0] idx;
        logic [7:0]           ch;
        idx = ROM_IDX_W'(code - 8'd1);
        ch  = 8'h00;
        if (code != 8'd0 && code <= 8'(ROM_LEN)) begin
            ch = shift ? ROM_SHIFT[idx] : ROM_PLAIN[idx];
        end
        return ch;
    endfunction

endpackage

// ----- rtl/s2a_ring.sv -----
// Character ring buffer: one memory with a registered read port, pointers and fill count.
module s2a_ring (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  s2a_pkg::ring_cmd_t    cmd,
    input  logic [7:0]            push_data,
    output logic [7:0]            pop_data,
    output s2a_pkg::ring_stat_t   stat
);

    logic [7:0]                 mem [s2a_pkg::BUFFER_DEPTH];
    logic [7:0]                 rd_data_reg;
    logic [s2a_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [s2a_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [s2a_pkg::CNT_W-1:0]  count_reg, count_next;

    localparam logic [s2a_pkg::PTR_W-1:0] PTR_LAST = s2a_pkg::PTR_W'(s2a_pkg::BUFFER_DEPTH - 1);
    localparam logic [s2a_pkg::CNT_W-1:0] CNT_FULL = s2a_pkg::CNT_W'(s2a_pkg::BUFFER_DEPTH);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end else if (cmd.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write port and registered read port; read data holds until the next pop.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (cmd.pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_data   = rd_data_reg;
    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !stat.full) else $error("push into full ring");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !stat.empty) else $error("pop from empty ring");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL) else $error("ring count overflow");
    a_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.pop)) else $error("push and pop together");
`endif

endmodule

// ----- rtl/scancode_to_ascii_ring_buffer_core.sv -----
// Top level: scancode decode, shift tracking and ring buffer control.
//
// Input channel s_valid/s_ready/s_data carries one transaction per item:
// func selects scancode decode, raw byte push or character read, and
// data_byte holds the scancode or raw byte. Every accepted item yields
// exactly one result transaction on m_valid/m_ready/m_data with the
// popped character, read and store flags and the fill level after the item.
// An item is accepted in the idle state; the accept cycle updates shift state,
// pointers and the buffer memory and issues the memory read; the work
// state then collects the registered read data into the output register,
// stalling while the receiver has not taken the previous result. A new item
// is accepted only once the previous one has left the work state.
// The output register lets the next item be accepted while a result is
// still waiting; if the receiver stalls, the following item waits in the
// work state until the output register frees, and s_ready stays low.
// Synchronous active-low reset empties the buffer and clears shift; the
// buffer memory itself is not cleared and needs no clearing pass.
module scancode_to_ascii_ring_buffer_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  s2a_pkg::s2a_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output s2a_pkg::s2a_out_t m_data
);

    typedef enum logic {
        S_IDLE,
        S_WORK
    } state_t;

    state_t              state_reg;
    logic                shift_reg, shift_next;
    logic                m_valid_reg;
    s2a_pkg::s2a_out_t   m_data_reg;
    logic                pend_pop_reg;
    logic                pend_stored_reg;

    logic                accept;
    logic                deliver;
    logic                do_push, do_pop;
    logic [7:0]          push_data;
    logic [7:0]          code_char;
    logic [7:0]          pop_data;
    s2a_pkg::ring_cmd_t  cmd;
    s2a_pkg::ring_stat_t stat;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign deliver = (state_reg == S_WORK) && (!m_valid_reg || m_ready);

    always_comb begin
        shift_next = shift_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        push_data  = s_data.data_byte;
        code_char  = 8'h00;
        case (s2a_pkg::func_t'(s_data.func))
            s2a_pkg::FUNC_SCAN: begin
                // a full buffer ignores the scancode, shift tracking included
                if (!stat.full) begin
                    if (s_data.data_byte == s2a_pkg::SC_LSHIFT ||
                        s_data.data_byte == s2a_pkg::SC_RSHIFT) begin
                        shift_next = 1'b1;
                    end
                    if (s_data.data_byte == s2a_pkg::SC_LSHIFT_BRK ||
                        s_data.data_byte == s2a_pkg::SC_RSHIFT_BRK) begin
                        shift_next = 1'b0;
                    end
                    code_char = s2a_pkg::s2a_lookup(shift_next, s_data.data_byte);
                    push_data = code_char;
                    do_push   = (code_char != 8'h00);
                end
            end
            s2a_pkg::FUNC_PUSH: begin
                do_push = !stat.full;
            end
            s2a_pkg::FUNC_READ: begin
                do_pop = !stat.empty;
            end
            default: begin
            end
        endcase
    end

    assign cmd.push = accept && do_push;
    assign cmd.pop  = accept && do_pop;

    s2a_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .push_data (push_data),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            shift_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            pend_pop_reg    <= 1'b0;
            pend_stored_reg <= 1'b0;
        end else begin
            if (deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        shift_reg       <= shift_next;
                        pend_pop_reg    <= do_pop;
                        pend_stored_reg <= do_push;
                        state_reg       <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (deliver) begin
                        m_data_reg.read_char  <= pend_pop_reg ? pop_data : s2a_pkg::CHAR_NONE;
                        m_data_reg.read_valid <= pend_pop_reg;
                        m_data_reg.stored     <= pend_stored_reg;
                        m_data_reg.fill_level <= s2a_pkg::FILL_W'(stat.count);
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_rd_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.read_valid && m_data.stored))
        else $error("result both read and stored");
    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.read_valid) |-> (m_data.read_char == s2a_pkg::CHAR_NONE))
        else $error("character without a read");
    a_accept_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_WORK))
        else $error("accepted item not in work");
`endif

endmodule
